### hw/rtl/btlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

    localparam int BYTE_W           = 8;
    localparam int COUNT_W          = 32;
    localparam int TAG_W            = 29;
    localparam int SIZE_W           = COUNT_W + 1;
    localparam int STATUS_W         = 4;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int MAX_TAG_BYTES    = 5;

    localparam int TBC_W            = $clog2(MAX_TAG_BYTES + 1);
    localparam int LBL_W            = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int HDR_CNT_W        = 4;

    localparam logic [4:0]         TAG_ESCAPE    = 5'h1f;
    localparam logic [TAG_W-1:0]   TAG_MAX       = 29'h1fffffff;
    localparam logic [TAG_W-1:0]   TAG_OVF_LIMIT = TAG_MAX >> 7;
    localparam logic [TAG_W-1:0]   MIN_HIGH_TAG  = 29'd31;
    localparam logic [BYTE_W-1:0]  TAG_LEAD_BAD  = 8'h80;
    localparam logic [COUNT_W-1:0] LEN_OVF_LIMIT = 32'h00ff_ffff;
    localparam logic [COUNT_W-1:0] MIN_LONG_LEN  = 32'h0000_0080;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 4'd0,
        ST_TAG_MISSING  = 4'd1,
        ST_TAG_LEAD     = 4'd2,
        ST_TAG_OVERFLOW = 4'd3,
        ST_BAD_HIGH_TAG = 4'd4,
        ST_LEN_MISSING  = 4'd5,
        ST_INDEFINITE   = 4'd6,
        ST_LEN_BOUND    = 4'd7,
        ST_LEN_LEAD_0   = 4'd8,
        ST_NONMINIMAL   = 4'd9
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [BYTE_W-1:0]    identifier_octet;
        logic [TAG_W-1:0]     tag_number;
        logic [COUNT_W-1:0]   value_length;
        logic [SIZE_W-1:0]    encoded_size;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/btlv_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface btlv_in_if;
    logic                              valid;
    logic                              ready;
    logic [btlv_pkg::BYTE_W-1:0]       data_byte;
    logic [btlv_pkg::COUNT_W-1:0]      bytes_after;
    logic                              restart;

    modport source (output valid, output data_byte, output bytes_after, output restart,
                    input ready);
    modport sink (input valid, input data_byte, input bytes_after, input restart,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/btlv_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface btlv_out_if;
    logic                              valid;
    logic                              ready;
    btlv_pkg::status_t                 status;
    logic [btlv_pkg::BYTE_W-1:0]       identifier_octet;
    logic [btlv_pkg::TAG_W-1:0]        tag_number;
    logic [btlv_pkg::COUNT_W-1:0]      value_length;
    logic [btlv_pkg::SIZE_W-1:0]       encoded_size;

    modport source (output valid, output status, output identifier_octet,
                    output tag_number, output value_length, output encoded_size,
                    input ready);
    modport sink (input valid, input status, input identifier_octet,
                  input tag_number, input value_length, input encoded_size,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/btlv_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module btlv_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    btlv_in_if.sink                    octets,
    input  wire logic                  res_ready,
    output      logic                  res_valid,
    output      btlv_pkg::result_t     res
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TAG       = 3'd1,
        PH_LEN_FIRST = 3'd2,
        PH_LEN_LONG  = 3'd3,
        PH_SKIP      = 3'd4
    } phase_t;

    // input register
    logic                                 in_valid_reg;
    logic [btlv_pkg::BYTE_W-1:0]          byte_reg;
    logic [btlv_pkg::COUNT_W-1:0]         after_reg;
    logic                                 restart_reg;

    // parse state
    phase_t                               phase_reg, phase_next;
    logic [btlv_pkg::BYTE_W-1:0]          ident_reg, ident_next;
    logic [btlv_pkg::TAG_W-1:0]           tag_reg, tag_next;
    logic [btlv_pkg::TBC_W-1:0]           tbc_reg, tbc_next;
    logic [btlv_pkg::LBL_W-1:0]           lbl_reg, lbl_next;
    logic [btlv_pkg::COUNT_W-1:0]         lacc_reg, lacc_next;
    logic [btlv_pkg::HDR_CNT_W-1:0]       hcnt_reg, hcnt_next;
    logic [btlv_pkg::COUNT_W-1:0]         vbl_reg, vbl_next;

    phase_t                               ph;
    logic                                 advance;
    logic                                 fail;
    btlv_pkg::status_t                    fail_code;
    logic                                 fin;
    logic [btlv_pkg::COUNT_W-1:0]         fin_len;
    logic [btlv_pkg::HDR_CNT_W-1:0]       hcnt_inc;
    logic [btlv_pkg::TAG_W-1:0]           tag_shift;
    logic [btlv_pkg::TBC_W-1:0]           tbc_inc;
    logic [btlv_pkg::COUNT_W-1:0]         lacc_shift;
    logic [btlv_pkg::LBL_W-1:0]           lbl_dec;
    logic [6:0]                           nlen;
    logic [btlv_pkg::COUNT_W-1:0]         vbl_dec;

    assign ph       = restart_reg ? PH_IDLE : phase_reg;
    assign advance  = in_valid_reg && (!res_valid || res_ready);
    assign octets.ready = !in_valid_reg || advance;

    assign hcnt_inc   = hcnt_reg + 1'b1;
    assign tag_shift  = {tag_reg[btlv_pkg::TAG_W-8:0], byte_reg[6:0]};
    assign tbc_inc    = tbc_reg + 1'b1;
    assign lacc_shift = {lacc_reg[btlv_pkg::COUNT_W-9:0], byte_reg};
    assign lbl_dec    = (lbl_reg != '0) ? lbl_reg - 1'b1 : '0;
    assign nlen       = byte_reg[6:0];
    assign vbl_dec    = vbl_reg - 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        ident_next = ident_reg;
        tag_next   = tag_reg;
        tbc_next   = tbc_reg;
        lbl_next   = lbl_reg;
        lacc_next  = lacc_reg;
        hcnt_next  = hcnt_reg;
        vbl_next   = vbl_reg;
        fail       = 1'b0;
        fail_code  = btlv_pkg::ST_OK;
        fin        = 1'b0;
        fin_len    = '0;
        res_valid  = 1'b0;
        res        = '0;

        unique case (ph)
            PH_SKIP:
            begin
                vbl_next = vbl_dec;
                if (vbl_dec == '0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_TAG:
            begin
                hcnt_next = hcnt_inc;
                if (tbc_reg == '0 && byte_reg == btlv_pkg::TAG_LEAD_BAD)
                begin
                    fail      = 1'b1;
                    fail_code = btlv_pkg::ST_TAG_LEAD;
                end
                else if (tag_reg > btlv_pkg::TAG_OVF_LIMIT)
                begin
                    fail      = 1'b1;
                    fail_code = btlv_pkg::ST_TAG_OVERFLOW;
                end
                else
                begin
                    tag_next = tag_shift;
                    tbc_next = tbc_inc;
                    if (!byte_reg[7])
                    begin
                        if (tag_shift < btlv_pkg::MIN_HIGH_TAG)
                        begin
                            fail      = 1'b1;
                            fail_code = btlv_pkg::ST_BAD_HIGH_TAG;
                        end
                        else if (after_reg == '0)
                        begin
                            fail      = 1'b1;
                            fail_code = btlv_pkg::ST_LEN_MISSING;
                        end
                        else
                        begin
                            phase_next = PH_LEN_FIRST;
                        end
                    end
                    else if (tbc_inc >= btlv_pkg::TBC_W'(btlv_pkg::MAX_TAG_BYTES))
                    begin
                        fail      = 1'b1;
                        fail_code = btlv_pkg::ST_BAD_HIGH_TAG;
                    end
                    else if (after_reg == '0)
                    begin
                        fail      = 1'b1;
                        fail_code = btlv_pkg::ST_TAG_MISSING;
                    end
                end
            end
            PH_LEN_FIRST:
            begin
                hcnt_next = hcnt_inc;
                if (!byte_reg[7])
                begin
                    fin     = 1'b1;
                    fin_len = {{(btlv_pkg::COUNT_W-btlv_pkg::BYTE_W){1'b0}}, byte_reg};
                end
                else if (nlen == '0)
                begin
                    fail      = 1'b1;
                    fail_code = btlv_pkg::ST_INDEFINITE;
                end
                else if (nlen > 7'(btlv_pkg::MAX_LENGTH_BYTES)
                         || {{(btlv_pkg::COUNT_W-7){1'b0}}, nlen} > after_reg)
                begin
                    fail      = 1'b1;
                    fail_code = btlv_pkg::ST_LEN_BOUND;
                end
                else
                begin
                    lbl_next   = btlv_pkg::LBL_W'(nlen);
                    lacc_next  = '0;
                    phase_next = PH_LEN_LONG;
                end
            end
            PH_LEN_LONG:
            begin
                hcnt_next = hcnt_inc;
                if (lacc_reg == '0 && byte_reg == '0)
                begin
                    fail      = 1'b1;
                    fail_code = btlv_pkg::ST_LEN_LEAD_0;
                end
                else if (lacc_reg > btlv_pkg::LEN_OVF_LIMIT)
                begin
                    fail      = 1'b1;
                    fail_code = btlv_pkg::ST_LEN_BOUND;
                end
                else
                begin
                    lacc_next = lacc_shift;
                    lbl_next  = lbl_dec;
                    if (lbl_dec == '0)
                    begin
                        if (lacc_shift < btlv_pkg::MIN_LONG_LEN)
                        begin
                            fail      = 1'b1;
                            fail_code = btlv_pkg::ST_NONMINIMAL;
                        end
                        else
                        begin
                            fin     = 1'b1;
                            fin_len = lacc_shift;
                        end
                    end
                end
            end
            default:
            begin
                ident_next = byte_reg;
                hcnt_next  = btlv_pkg::HDR_CNT_W'(1);
                tbc_next   = '0;
                lbl_next   = '0;
                lacc_next  = '0;
                vbl_next   = '0;
                if (byte_reg[4:0] == btlv_pkg::TAG_ESCAPE)
                begin
                    tag_next = '0;
                    if (after_reg == '0)
                    begin
                        fail      = 1'b1;
                        fail_code = btlv_pkg::ST_TAG_MISSING;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
                else
                begin
                    tag_next = {{(btlv_pkg::TAG_W-5){1'b0}}, byte_reg[4:0]};
                    if (after_reg == '0)
                    begin
                        fail      = 1'b1;
                        fail_code = btlv_pkg::ST_LEN_MISSING;
                    end
                    else
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
            end
        endcase

        if (fin)
        begin
            if (fin_len > after_reg)
            begin
                fail      = 1'b1;
                fail_code = btlv_pkg::ST_LEN_BOUND;
            end
            else
            begin
                res_valid            = in_valid_reg;
                res.status           = btlv_pkg::ST_OK;
                res.identifier_octet = ident_reg;
                res.tag_number       = tag_reg;
                res.value_length     = fin_len;
                res.encoded_size     = {1'b0, fin_len}
                                     + {{(btlv_pkg::SIZE_W-btlv_pkg::HDR_CNT_W){1'b0}},
                                        hcnt_inc};
                vbl_next             = fin_len;
                phase_next           = (fin_len == '0) ? PH_IDLE : PH_SKIP;
            end
        end

        if (fail)
        begin
            res_valid  = in_valid_reg;
            res        = '0;
            res.status = fail_code;
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            ident_reg    <= '0;
            tag_reg      <= '0;
            tbc_reg      <= '0;
            lbl_reg      <= '0;
            lacc_reg     <= '0;
            hcnt_reg     <= '0;
            vbl_reg      <= '0;
        end
        else
        begin
            if (octets.ready)
            begin
                in_valid_reg <= octets.valid;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                ident_reg <= ident_next;
                tag_reg   <= tag_next;
                tbc_reg   <= tbc_next;
                lbl_reg   <= lbl_next;
                lacc_reg  <= lacc_next;
                hcnt_reg  <= hcnt_next;
                vbl_reg   <= vbl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (octets.valid && octets.ready)
        begin
            byte_reg    <= octets.data_byte;
            after_reg   <= octets.bytes_after;
            restart_reg <= octets.restart;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/btlv_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module btlv_out_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  res_valid,
    input  wire btlv_pkg::result_t     res,
    output      logic                  res_ready,
    btlv_out_if.source                 tlvs
);

    logic                 valid_reg;
    btlv_pkg::result_t    data_reg;

    assign res_ready             = !valid_reg || tlvs.ready;
    assign tlvs.valid            = valid_reg;
    assign tlvs.status           = data_reg.status;
    assign tlvs.identifier_octet = data_reg.identifier_octet;
    assign tlvs.tag_number       = data_reg.tag_number;
    assign tlvs.value_length     = data_reg.value_length;
    assign tlvs.encoded_size     = data_reg.encoded_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ber_tlv_header_parser.sv
// BER TLV header parser. Takes one message byte per word together with the
// count of buffer bytes that follow it, and gives one word per TLV: a header
// descriptor, or an error status as soon as a canonical or bound check fails,
// after which the next byte is taken as an identifier octet. Value bytes are
// skipped with no output. One byte is taken every cycle while input ready
// is high; a byte passes an input register and, when it closes a header or
// fails, a result register. Input ready drops only while a result waits in
// the result register and the byte held in the input register would produce
// another one.
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_header_parser (
    input  wire logic      clk,
    input  wire logic      rst_n,
    btlv_in_if.sink        octets,
    btlv_out_if.source     tlvs
);

    logic                 res_valid;
    logic                 res_ready;
    btlv_pkg::result_t    res;

    btlv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .octets    (octets),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    btlv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .tlvs      (tlvs)
    );

`ifndef ASSERT_OFF
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tlvs.valid && tlvs.status != btlv_pkg::ST_OK) |->
        (tlvs.identifier_octet == '0 && tlvs.tag_number == '0
         && tlvs.value_length == '0 && tlvs.encoded_size == '0))
        else $error("error word carries nonzero fields");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        tlvs.valid |-> (tlvs.status <= btlv_pkg::ST_NONMINIMAL))
        else $error("status code out of range");

    a_header_size: assert property (@(posedge clk) disable iff (!rst_n)
        (tlvs.valid && tlvs.status == btlv_pkg::ST_OK) |->
        (tlvs.encoded_size >= {1'b0, tlvs.value_length} + 33'd2
         && tlvs.encoded_size <= {1'b0, tlvs.value_length} + 33'd11))
        else $error("header size out of range");

    a_high_tag_min: assert property (@(posedge clk) disable iff (!rst_n)
        (tlvs.valid && tlvs.status == btlv_pkg::ST_OK
         && tlvs.identifier_octet[4:0] == btlv_pkg::TAG_ESCAPE) |->
        (tlvs.tag_number >= btlv_pkg::MIN_HIGH_TAG))
        else $error("high tag form below minimum");
`endif

endmodule

`default_nettype wire
